[design/bpsm_pkg.sv]
// ----------------------------------------------------------------------------
// bpsm_pkg
// Shared types, constants and helpers of the stereo message update block.
// ----------------------------------------------------------------------------
package bpsm_pkg;

    localparam int MAX_PLANES = 64;
    localparam int AW         = $clog2(MAX_PLANES);
    localparam int CW         = AW + 1;
    localparam int SUM_W      = 16 + AW;
    localparam int DCNT_W     = $clog2(SUM_W + 1);

    localparam logic [15:0] MIN_START = 16'd30000;

    // four lanes: north, west, south, east
    typedef logic [3:0][15:0]      t_word;
    typedef logic [3:0][SUM_W-1:0] t_sums;

    typedef enum logic [1:0] {
        CFG_PLANES = 2'd0,
        CFG_JUMP   = 2'd1,
        CFG_TRUNC  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FWD,
        ST_BWD,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic          start;
        logic [CW-1:0] divisor;
        t_sums         dividend;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quot;
    } t_div_rsp;

    function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

endpackage

[design/bpsm_vec_ram.sv]
// ----------------------------------------------------------------------------
// bpsm_vec_ram
// Vector store: one word per plane, four 16-bit lanes, registered read.
// ----------------------------------------------------------------------------
module bpsm_vec_ram
    import bpsm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_word         o_rdata
);

    t_word r_mem [MAX_PLANES];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bpsm_div.sv]
// ----------------------------------------------------------------------------
// bpsm_div
// Four-lane restoring divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module bpsm_div
    import bpsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [CW-1:0]     r_div;
    logic [3:0]        r_neg;
    logic [3:0][CW:0]  r_rem;
    t_sums             r_q;

    logic [3:0][CW:0]  n_rem;
    t_sums             n_q;

    always_comb begin
        logic [CW:0] rsh;
        for (int k = 0; k < 4; k++) begin
            rsh = {r_rem[k][CW-1:0], r_q[k][SUM_W-1]};
            if (rsh >= {1'b0, r_div}) begin
                n_rem[k] = rsh - {1'b0, r_div};
                n_q[k]   = {r_q[k][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = rsh;
                n_q[k]   = {r_q[k][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
            for (int k = 0; k < 4; k++) begin
                r_neg[k] <= i_req.dividend[k][SUM_W-1];
                r_q[k]   <= i_req.dividend[k][SUM_W-1] ? -i_req.dividend[k]
                                                       : i_req.dividend[k];
                r_rem[k] <= '0;
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        for (int k = 0; k < 4; k++) begin
            o_rsp.quot[k] = r_neg[k] ? -r_q[k][15:0] : r_q[k][15:0];
        end
    end

endmodule

[design/bp_stereo_message_update_core.sv]
// ----------------------------------------------------------------------------
// bp_stereo_message_update_core
// Min-sum message update with truncated linear cost for one stereo pixel.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one disparity plane per
// request; a pixel vector is complete after planes_in_use planes (clamped to
// 1..64). While loading, one plane is taken per cycle.
// After the last plane the block runs, over the vector memory with one
// registered read port, a forward pass, a backward pass with clamp and
// lane sums, a mean divide of 22 quotient steps, and an emit pass of one
// result per plane, whose next read waits until the previous result has
// moved into the output register. No input is taken from the last plane
// until the final result has moved into the output register.
// Output channel (o_out_valid / i_out_ready) holds its result while the
// receiver stalls; the emit pass waits on it.
// Config writes (i_cfg_valid / o_cfg_ready) are always taken; they are meant
// for idle time only. Reset returns the registers to 16, 10 and 160, clears
// the plane count and sets the running minima to 30000.
// ----------------------------------------------------------------------------
module bp_stereo_message_update_core
    import bpsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_data_cost,
    input  logic [15:0] i_msg_from_north,
    input  logic [15:0] i_msg_from_west,
    input  logic [15:0] i_msg_from_south,
    input  logic [15:0] i_msg_from_east,
    input  logic        i_at_top,
    input  logic        i_at_left,
    input  logic        i_at_bottom,
    input  logic        i_at_right,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_plane_index,
    output logic [15:0] o_msg_to_north,
    output logic [15:0] o_msg_to_west,
    output logic [15:0] o_msg_to_south,
    output logic [15:0] o_msg_to_east,
    output logic        o_last_result
);

    t_state        r_state, n_state;
    logic [6:0]    r_planes;
    logic [14:0]   r_jump;
    logic [14:0]   r_trunc;
    logic [CW-1:0] r_cnt;
    t_word         r_min;
    logic [CW-1:0] r_idx;
    logic          r_dv;
    logic          r_inflight;
    logic [AW-1:0] r_paddr;
    logic          r_plast;
    logic          r_pfirst;
    t_word         r_prev;
    t_sums         r_sum;
    t_word         r_mean;
    logic          r_divstart;
    logic          r_ovalid;
    logic [5:0]    r_oplane;
    t_word         r_omsg;
    logic          r_olast;

    logic [CW-1:0] w_n;
    logic          w_in_acc;
    logic          w_load_done;
    logic          w_issue;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_word         w_wdata;
    t_word         w_v;
    t_word         w_new;
    t_word         w_clamp;
    t_word         w_rdata;
    logic          w_pass_last;
    logic          w_xfer;
    t_div_req      w_div_req;
    t_div_rsp      w_div_rsp;

    bpsm_vec_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_div_req.start    = r_divstart;
    assign w_div_req.divisor  = w_n;
    assign w_div_req.dividend = r_sum;

    bpsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_LOAD);
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        if (r_planes == 7'd0) begin
            w_n = CW'(1);
        end else if (int'(r_planes) > MAX_PLANES) begin
            w_n = CW'(MAX_PLANES);
        end else begin
            w_n = CW'(r_planes);
        end
    end

    // per-direction sums, each excluding its own message
    always_comb begin
        logic [15:0] pn, pw, ps, pe;
        pn = i_at_top    ? 16'd0 : i_msg_from_north;
        pw = i_at_left   ? 16'd0 : i_msg_from_west;
        ps = i_at_bottom ? 16'd0 : i_msg_from_south;
        pe = i_at_right  ? 16'd0 : i_msg_from_east;
        w_v[0] = i_data_cost + pw + ps + pe;
        w_v[1] = i_data_cost + pn + ps + pe;
        w_v[2] = i_data_cost + pn + pw + pe;
        w_v[3] = i_data_cost + pn + pw + ps;
    end

    assign w_load_done = w_in_acc && ((r_cnt + 1'b1) >= w_n);
    assign w_pass_last = r_dv && r_plast;
    assign w_xfer      = (r_state == ST_EMIT) && r_dv && (!r_ovalid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (w_load_done) n_state = ST_FWD;
            ST_FWD:  if (w_pass_last) n_state = ST_BWD;
            ST_BWD:  if (w_pass_last) n_state = ST_DIV;
            ST_DIV:  if (w_div_rsp.done) n_state = ST_EMIT;
            ST_EMIT: if (w_xfer && r_plast) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // datapath control
    always_comb begin
        logic [15:0] cand, cap;
        w_issue = 1'b0;
        w_raddr = r_idx[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_paddr;
        w_wdata = w_v;
        for (int k = 0; k < 4; k++) begin
            cand       = r_prev[k] + {1'b0, r_jump};
            cap        = r_min[k] + {1'b0, r_trunc};
            w_new[k]   = r_pfirst ? w_rdata[k] : min16(w_rdata[k], cand);
            w_clamp[k] = min16(w_new[k], cap);
        end
        case (r_state)
            ST_LOAD: begin
                w_we    = w_in_acc;
                w_waddr = r_cnt[AW-1:0];
            end
            ST_FWD: begin
                w_issue = (r_idx < w_n);
                w_we    = r_dv;
                w_wdata = w_new;
            end
            ST_BWD: begin
                w_issue = (r_idx < w_n);
                w_raddr = AW'(w_n - 1'b1 - r_idx);
                w_we    = r_dv;
                w_wdata = w_clamp;
            end
            ST_EMIT: begin
                w_issue = (r_idx < w_n) && !r_inflight;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_planes   <= 7'd16;
            r_jump     <= 15'd10;
            r_trunc    <= 15'd160;
            r_cnt      <= '0;
            r_min      <= {4{MIN_START}};
            r_idx      <= '0;
            r_dv       <= 1'b0;
            r_inflight <= 1'b0;
            r_divstart <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_divstart <= (r_state == ST_BWD) && w_pass_last;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PLANES: r_planes <= i_cfg_data[6:0];
                    CFG_JUMP:   r_jump   <= i_cfg_data;
                    CFG_TRUNC:  r_trunc  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_in_acc) begin
                r_cnt <= w_load_done ? '0 : r_cnt + 1'b1;
                for (int k = 0; k < 4; k++) begin
                    r_min[k] <= min16(w_v[k], r_min[k]);
                end
            end

            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end else if (w_pass_last || w_div_rsp.done) begin
                r_idx <= '0;
            end

            if (r_state == ST_EMIT) begin
                if (w_issue) begin
                    r_inflight <= 1'b1;
                end else if (w_xfer) begin
                    r_inflight <= 1'b0;
                end
                r_dv <= w_issue ? 1'b1 : (w_xfer ? 1'b0 : r_dv);
            end else begin
                r_inflight <= 1'b0;
                r_dv       <= w_issue;
            end

            if (w_xfer) begin
                r_ovalid <= 1'b1;
                if (r_plast) begin
                    r_min <= {4{MIN_START}};
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_paddr  <= w_raddr;
            r_plast  <= (r_idx == w_n - 1'b1);
            r_pfirst <= (r_idx == '0);
        end
        if (r_dv && (r_state == ST_FWD || r_state == ST_BWD)) begin
            r_prev <= w_new;
        end
        if ((r_state == ST_FWD) && w_pass_last) begin
            r_sum <= '0;
        end else if ((r_state == ST_BWD) && r_dv) begin
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= r_sum[k] + SUM_W'($signed(w_clamp[k]));
            end
        end
        if (w_div_rsp.done) begin
            r_mean <= w_div_rsp.quot;
        end
        if (w_xfer) begin
            r_oplane <= 6'(r_paddr);
            r_olast  <= r_plast;
            for (int k = 0; k < 4; k++) begin
                r_omsg[k] <= w_rdata[k] - r_mean[k];
            end
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_plane_index  = r_oplane;
    assign o_msg_to_north = r_omsg[0];
    assign o_msg_to_west  = r_omsg[1];
    assign o_msg_to_south = r_omsg[2];
    assign o_msg_to_east  = r_omsg[3];
    assign o_last_result  = r_olast;

endmodule

[design/bpsm_checker.sv]
// ----------------------------------------------------------------------------
// bpsm_checker
// Port-level checks of the stereo message update core, bound to the top.
// ----------------------------------------------------------------------------
module bpsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_plane_index,
    input logic [15:0] o_msg_to_north,
    input logic [15:0] o_msg_to_west,
    input logic [15:0] o_msg_to_south,
    input logic [15:0] o_msg_to_east,
    input logic        o_last_result
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_plane_index) && $stable(o_msg_to_north)
            && $stable(o_msg_to_west) && $stable(o_msg_to_south)
            && $stable(o_msg_to_east) && $stable(o_last_result))
        else $error("stalled result changed");

    // inputs are taken only once the vector's last result is out
    a_no_load_mid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_result |-> !o_in_ready)
        else $error("input request taken during emission");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind bp_stereo_message_update_core bpsm_checker u_bpsm_checker (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives disparity planes into the stereo message update core, predicts each
// pixel vector's outgoing messages in-line and checks every emitted plane.
// ----------------------------------------------------------------------------
module testbench;
    import bpsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [14:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_data_cost;
    logic [15:0] i_msg_from_north;
    logic [15:0] i_msg_from_west;
    logic [15:0] i_msg_from_south;
    logic [15:0] i_msg_from_east;
    logic        i_at_top;
    logic        i_at_left;
    logic        i_at_bottom;
    logic        i_at_right;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [5:0]  o_plane_index;
    logic [15:0] o_msg_to_north;
    logic [15:0] o_msg_to_west;
    logic [15:0] o_msg_to_south;
    logic [15:0] o_msg_to_east;
    logic        o_last_result;

    typedef struct packed {
        logic [5:0]  plane;
        logic [15:0] to_n;
        logic [15:0] to_w;
        logic [15:0] to_s;
        logic [15:0] to_e;
        logic        last;
    } t_plane_msg;

    bp_stereo_message_update_core DUT (.*);

    // model state
    logic signed [15:0] lane_store [4][MAX_PLANES];
    logic signed [15:0] lane_min   [4];
    int                 planes_loaded;
    int                 cfg_planes;
    int                 cfg_jump;
    int                 cfg_trunc;

    t_plane_msg expected_msgs[$];
    int         errors;
    int         planes_sent;
    int         msgs_checked;
    int         vectors_done;
    longint     cycle_count;
    bit         idle_on;
    bit         hold_off;
    int         hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // refine one lane vector in place
    task automatic refine_lane(int k, int n);
        logic signed [15:0] cand;
        logic signed [15:0] cap;
        int                 sum;
        int                 mean;
        sum = 0;
        for (int d = 1; d < n; d++) begin
            cand = lane_store[k][d-1] + 16'(cfg_jump);
            if (cand < lane_store[k][d]) lane_store[k][d] = cand;
        end
        for (int d = n - 1; d > 0; d--) begin
            cand = lane_store[k][d] + 16'(cfg_jump);
            if (cand < lane_store[k][d-1]) lane_store[k][d-1] = cand;
        end
        cap = lane_min[k] + 16'(cfg_trunc);
        for (int d = 0; d < n; d++)
            if (cap < lane_store[k][d]) lane_store[k][d] = cap;
        for (int d = 0; d < n; d++) sum += int'(lane_store[k][d]);
        mean = sum / n;
        for (int d = 0; d < n; d++) lane_store[k][d] = lane_store[k][d] - 16'(mean);
    endtask

    task automatic predict_plane(logic [15:0] dc, logic [15:0] mn, logic [15:0] mw,
                                 logic [15:0] ms, logic [15:0] me, logic [3:0] flags);
        logic signed [15:0] pn, pw, ps, pe;
        logic signed [15:0] v [4];
        t_plane_msg         msg;
        int                 n;
        pn = flags[0] ? 16'sd0 : mn;
        pw = flags[1] ? 16'sd0 : mw;
        ps = flags[2] ? 16'sd0 : ms;
        pe = flags[3] ? 16'sd0 : me;
        v[0] = dc + pw + ps + pe;
        v[1] = dc + pn + ps + pe;
        v[2] = dc + pn + pw + pe;
        v[3] = dc + pn + pw + ps;
        for (int k = 0; k < 4; k++) begin
            if (planes_loaded < MAX_PLANES) lane_store[k][planes_loaded] = v[k];
            if (v[k] < lane_min[k]) lane_min[k] = v[k];
        end
        planes_loaded++;
        n = cfg_planes < 1 ? 1 : (cfg_planes > MAX_PLANES ? MAX_PLANES : cfg_planes);
        if (planes_loaded < n) return;
        for (int k = 0; k < 4; k++) refine_lane(k, n);
        for (int d = 0; d < n; d++) begin
            msg.plane = 6'(d);
            msg.to_n  = lane_store[0][d];
            msg.to_w  = lane_store[1][d];
            msg.to_s  = lane_store[2][d];
            msg.to_e  = lane_store[3][d];
            msg.last  = (d == n - 1);
            expected_msgs.push_back(msg);
        end
        for (int k = 0; k < 4; k++) lane_min[k] = MIN_START;
        planes_loaded = 0;
        vectors_done++;
    endtask

    // drop the request line only while idling
    task automatic random_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_plane(logic [15:0] dc, logic [15:0] mn, logic [15:0] mw,
                              logic [15:0] ms, logic [15:0] me, logic [3:0] flags);
        random_gap();
        i_in_valid       <= 1'b1;
        i_data_cost      <= dc;
        i_msg_from_north <= mn;
        i_msg_from_west  <= mw;
        i_msg_from_south <= ms;
        i_msg_from_east  <= me;
        {i_at_right, i_at_bottom, i_at_left, i_at_top} <= flags;
        do @(posedge i_clk); while (!o_in_ready);
        predict_plane(dc, mn, mw, ms, me, flags);
        planes_sent++;
    endtask

    task automatic send_random_plane(int span);
        logic [15:0] f [5];
        for (int j = 0; j < 5; j++)
            f[j] = span == 0 ? 16'($urandom)
                             : 16'($signed(int'($urandom_range(0, 2 * span)) - span));
        send_plane(f[0], f[1], f[2], f[3], f[4], 4'($urandom_range(0, 15)));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [14:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PLANES: cfg_planes = int'(value[6:0]);
            CFG_JUMP:   cfg_jump   = int'(value);
            default:    cfg_trunc  = int'(value);
        endcase
    endtask

    // hold until every expected plane has come out, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_msgs.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        logic [15:0] corner [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        write_reg(CFG_PLANES, 15'd4);
        for (int r = 0; r < 2; r++)
            for (int p = 0; p < 4; p++)
                send_plane(corner[(p + r) % 4], corner[p], corner[(p + 1) % 4],
                           corner[(p + 2) % 4], corner[(p + 3) % 4], 4'(r * 5 + p));
        drain();
    endtask

    task automatic test_plane_count_edges();
        // zero clamps to one plane, large counts clamp to the store depth
        write_reg(CFG_PLANES, 15'd0);
        send_random_plane(0);
        drain();
        write_reg(CFG_PLANES, 15'd1);
        send_random_plane(0);
        drain();
        write_reg(CFG_JUMP, 15'h7FFF);
        write_reg(CFG_TRUNC, 15'h7FFF);
        write_reg(CFG_PLANES, 15'd127);
        for (int p = 0; p < MAX_PLANES; p++) send_random_plane(300);
        drain();
        // count lowered mid-vector completes early
        write_reg(CFG_PLANES, 15'd8);
        for (int p = 0; p < 5; p++) send_random_plane(200);
        drain();
        write_reg(CFG_PLANES, 15'd3);
        send_random_plane(200);
        drain();
    endtask

    task automatic test_random_vectors();
        int n;
        int plane_target;
        plane_target = planes_sent + 14;
        while (planes_sent < plane_target) begin
            n = $urandom_range(2, 8);
            write_reg(CFG_PLANES, 15'(n));
            write_reg(CFG_JUMP, 15'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)));
            write_reg(CFG_TRUNC, 15'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400)));
            for (int p = 0; p < n; p++)
                send_random_plane($urandom_range(0, 4) == 0 ? 0 : 1000);
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_PLANES, 15'd2);
        hold_cycles = 400;
        hold_off    = 1'b1;
        for (int p = 0; p < 6; p++) send_random_plane(500);
        drain();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_reg(CFG_PLANES, 15'd6);
        write_reg(CFG_JUMP, 15'd10);
        write_reg(CFG_TRUNC, 15'd160);
        for (int p = 0; p < 12; p++) send_random_plane(800);
        drain();
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off) begin
            i_out_ready <= 1'b0;
            if (hold_cycles == 0) hold_off <= 1'b0;
            else hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= !idle_on || $urandom_range(0, 3) != 0;
        end
    end

    always @(posedge i_clk) begin
        t_plane_msg want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_msgs.size() == 0) begin
                $display("%0t: unexpected plane %0d", $realtime, o_plane_index);
                errors++;
            end else begin
                want = expected_msgs.pop_front();
                msgs_checked++;
                if (o_plane_index !== want.plane) begin
                    $display("%0t: plane_index exp %0d got %0d", $realtime, want.plane, o_plane_index);
                    errors++;
                end
                if (o_msg_to_north !== want.to_n) begin
                    $display("%0t: msg_to_north exp %0d got %0d", $realtime,
                             $signed(want.to_n), $signed(o_msg_to_north));
                    errors++;
                end
                if (o_msg_to_west !== want.to_w) begin
                    $display("%0t: msg_to_west exp %0d got %0d", $realtime,
                             $signed(want.to_w), $signed(o_msg_to_west));
                    errors++;
                end
                if (o_msg_to_south !== want.to_s) begin
                    $display("%0t: msg_to_south exp %0d got %0d", $realtime,
                             $signed(want.to_s), $signed(o_msg_to_south));
                    errors++;
                end
                if (o_msg_to_east !== want.to_e) begin
                    $display("%0t: msg_to_east exp %0d got %0d", $realtime,
                             $signed(want.to_e), $signed(o_msg_to_east));
                    errors++;
                end
                if (o_last_result !== want.last) begin
                    $display("%0t: last_result exp %0b got %0b", $realtime, want.last, o_last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout with %0d planes outstanding", expected_msgs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        errors = 0; planes_sent = 0; msgs_checked = 0; vectors_done = 0;
        cycle_count = 0; idle_on = 1'b1; hold_off = 1'b0; hold_cycles = 0;
        planes_loaded = 0; cfg_planes = 16; cfg_jump = 10; cfg_trunc = 160;
        for (int k = 0; k < 4; k++) lane_min[k] = MIN_START;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_index = CFG_PLANES; i_cfg_data = '0;
        i_in_valid = 1'b0; i_data_cost = '0; i_msg_from_north = '0; i_msg_from_west = '0;
        i_msg_from_south = '0; i_msg_from_east = '0; i_at_top = 1'b0; i_at_left = 1'b0;
        i_at_bottom = 1'b0; i_at_right = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_plane_count_edges();
        test_random_vectors();
        test_backpressure();
        test_steady_stream();
        $display("Covered %0d planes in %0d vectors, %0d outgoing planes checked,",
                 planes_sent, vectors_done, msgs_checked);
        $display("plane counts 1..64 with clamping, extreme costs and output backpressure.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
